FILE: hw/rtl/mcms_pkg.sv
// Shared types and codes for the maze cell map store.
// No dependencies; used by mcms_sweep and maze_cell_map_store_top.
`default_nettype none

package mcms_pkg;

  localparam logic [2:0] KIND_SET_WALL   = 3'd0;
  localparam logic [2:0] KIND_QUERY_WALL = 3'd1;
  localparam logic [2:0] KIND_SET_DIST   = 3'd2;
  localparam logic [2:0] KIND_GET_DIST   = 3'd3;
  localparam logic [2:0] KIND_MARK_VIS   = 3'd4;
  localparam logic [2:0] KIND_QUERY_VIS  = 3'd5;
  localparam logic [2:0] KIND_CLEAR      = 3'd6;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  localparam logic CFG_GOAL_X = 1'b0;
  localparam logic CFG_GOAL_Y = 1'b1;

  localparam logic [7:0] DIST_INVALID = 8'd255;

  typedef struct packed {
    logic start;
  } sweep_ctrl_t;

  typedef struct packed {
    logic       en;
    logic       walls_en;
    logic       last;
    logic [3:0] walls;
    logic [7:0] distance;
  } sweep_wr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mcms_sweep.sv
// Cell sweep generator: walks every cell once after reset (boundary walls,
// distance to centre) and on a clear request (distance to goal). Uses mcms_pkg.
`default_nettype none

module mcms_sweep #(
  parameter int unsigned GRID_SIDE = 16,
  parameter int unsigned AW        = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mcms_pkg::sweep_ctrl_t ctrl_i,
  input  logic [3:0]            goal_x_i,
  input  logic [3:0]            goal_y_i,
  output mcms_pkg::sweep_wr_t   wr_o,
  output logic [AW-1:0]         addr_o
);

  localparam int unsigned CW   = $clog2(GRID_SIDE);
  localparam int unsigned LO   = GRID_SIDE / 2 - 1;
  localparam int unsigned HI   = GRID_SIDE / 2;
  localparam int unsigned MAXC = GRID_SIDE - 1;

  logic          active_q, active_d;
  logic          clear_q, clear_d;
  logic [CW-1:0] cx_q, cx_d;
  logic [CW-1:0] cy_q, cy_d;

  logic       last;
  logic [7:0] cx8, cy8, gx8, gy8;
  logic [7:0] dx_goal, dy_goal, dx_ctr, dy_ctr;

  always_comb begin
    cx8 = 8'(cx_q);
    cy8 = 8'(cy_q);
    gx8 = 8'(goal_x_i);
    gy8 = 8'(goal_y_i);
    dx_goal = (cx8 > gx8) ? cx8 - gx8 : gx8 - cx8;
    dy_goal = (cy8 > gy8) ? cy8 - gy8 : gy8 - cy8;
    dx_ctr  = (cx8 <= 8'(LO)) ? 8'(LO) - cx8 : cx8 - 8'(HI);
    dy_ctr  = (cy8 <= 8'(LO)) ? 8'(LO) - cy8 : cy8 - 8'(HI);
    last    = (cx_q == CW'(MAXC)) && (cy_q == CW'(MAXC));
  end

  always_comb begin
    wr_o.en       = active_q;
    wr_o.walls_en = active_q && !clear_q;
    wr_o.last     = active_q && last;
    wr_o.walls    = {cx_q == '0, cy_q == '0, cx_q == CW'(MAXC), cy_q == CW'(MAXC)};
    wr_o.distance = clear_q ? dx_goal + dy_goal : dx_ctr + dy_ctr;
    addr_o        = AW'(AW'(cx_q) * AW'(GRID_SIDE) + AW'(cy_q));
  end

  always_comb begin
    active_d = active_q;
    clear_d  = clear_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    if (active_q) begin
      if (last) begin
        active_d = 1'b0;
        cx_d     = '0;
        cy_d     = '0;
      end else if (cy_q == CW'(MAXC)) begin
        cy_d = '0;
        cx_d = cx_q + 1'b1;
      end else begin
        cy_d = cy_q + 1'b1;
      end
    end else if (ctrl_i.start) begin
      active_d = 1'b1;
      clear_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b1;
      clear_q  <= 1'b0;
      cx_q     <= '0;
      cy_q     <= '0;
    end else begin
      active_q <= active_d;
      clear_q  <= clear_d;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/maze_cell_map_store_top.sv
// Maze cell map store: wall, distance and visited memories with their
// read-modify-write control. Depends on mcms_pkg and mcms_sweep.
//
//  channel   direction  payload
//  s_axis    in         tuser: kind; tdata: pos_x, pos_y, direction, wall_present,
//                       distance_value
//  m_axis    out        tdata: wall_seen, distance_out, visited_out
//  cfg       in         cfg_index_i selects goal_x or goal_y, cfg_data_i value
//
// Queries, distance writes and visited marks run as a memory read, then a modify
// and write back. Wall writes with the neighbor inside the grid add a step: the
// neighbor cell is read as the cell is written back, and is written in ST_NB
// through the same wall memory. Clear sweeps one cell per cycle. After reset a
// sweep loads the memories while s_axis_tready stays low; cfg writes are held
// off in ST_EXEC and while a clear sweeps.
// A full result register stalls the finishing cycle, not input acceptance.
`default_nettype none

module maze_cell_map_store_top #(
  parameter int unsigned GRID_SIDE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // pos_x[7:0], pos_y[15:8], direction[17:16],
                                     // wall_present[18], distance_value[26:19]
  input  logic [2:0]  s_axis_tuser,  // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // wall_seen[0], distance_out[8:1], visited_out[9]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_data_i
);

  localparam int unsigned CW    = $clog2(GRID_SIDE);
  localparam int unsigned CELLS = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AW    = $clog2(CELLS);

  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_NB   = 3'd3;
  localparam logic [2:0] ST_CLR  = 3'd4;

  function automatic logic [3:0] wall_update(logic [3:0] w, logic [1:0] d, logic set);
    logic [3:0] b;
    b = 4'b0001 << d;
    return set ? (w | b) : (w & ~b);
  endfunction

  logic [2:0] state_q, state_d;
  logic [3:0] goal_x_q, goal_y_q;

  logic [3:0] wall_mem [CELLS];
  logic [8:0] dv_mem   [CELLS];
  logic [3:0] wall_rd_q;
  logic [8:0] dv_rd_q;

  logic          wall_we, wall_re, dv_we, dv_re;
  logic [AW-1:0] wall_waddr, wall_raddr, dv_waddr, dv_raddr;
  logic [3:0]    wall_wdata;
  logic [8:0]    dv_wdata;

  logic [2:0]    kind_q;
  logic [1:0]    dir_q;
  logic          pres_q, ok_q, nb_ok_q;
  logic [7:0]    dval_q;
  logic [AW-1:0] addr_q, nb_addr_q;

  logic       m_valid_q, m_valid_d;
  logic [9:0] m_data_q, m_data_d;
  logic       out_free, accept, finish;

  logic [7:0]    in_x, in_y, nb_x, nb_y, in_dval;
  logic [1:0]    in_dir;
  logic          in_ok, nb_ok;
  logic [AW-1:0] in_addr, nb_addr;

  mcms_pkg::sweep_ctrl_t sw_ctrl;
  mcms_pkg::sweep_wr_t   sw_wr;
  logic [AW-1:0]         sw_addr;

  mcms_sweep #(
    .GRID_SIDE(GRID_SIDE),
    .AW       (AW)
  ) u_sweep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (sw_ctrl),
    .goal_x_i(goal_x_q),
    .goal_y_i(goal_y_q),
    .wr_o    (sw_wr),
    .addr_o  (sw_addr)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = (state_q != ST_EXEC) && (state_q != ST_CLR);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, m_data_q};
  assign out_free      = !m_valid_q || m_axis_tready;
  assign finish        = (state_q == ST_EXEC) && out_free;

  always_comb begin
    in_x    = s_axis_tdata[7:0];
    in_y    = s_axis_tdata[15:8];
    in_dir  = s_axis_tdata[17:16];
    in_dval = s_axis_tdata[26:19];
    in_ok   = (in_x < 8'(GRID_SIDE)) && (in_y < 8'(GRID_SIDE));
    nb_x    = in_x;
    nb_y    = in_y;
    case (in_dir)
      mcms_pkg::DIR_N: nb_y = in_y + 8'd1;
      mcms_pkg::DIR_E: nb_x = in_x + 8'd1;
      mcms_pkg::DIR_S: nb_y = in_y - 8'd1;
      mcms_pkg::DIR_W: nb_x = in_x - 8'd1;
      default: nb_x = in_x;
    endcase
    nb_ok   = in_ok && (nb_x < 8'(GRID_SIDE)) && (nb_y < 8'(GRID_SIDE));
    in_addr = AW'(AW'(in_x[CW-1:0]) * AW'(GRID_SIDE) + AW'(in_y[CW-1:0]));
    nb_addr = AW'(AW'(nb_x[CW-1:0]) * AW'(GRID_SIDE) + AW'(nb_y[CW-1:0]));
  end

  always_comb begin
    state_d       = state_q;
    sw_ctrl.start = 1'b0;
    wall_we       = sw_wr.walls_en;
    wall_waddr    = sw_addr;
    wall_wdata    = sw_wr.walls;
    dv_we         = sw_wr.en;
    dv_waddr      = sw_addr;
    dv_wdata      = {1'b0, sw_wr.distance};
    wall_re       = accept;
    wall_raddr    = in_addr;
    dv_re         = accept;
    dv_raddr      = in_addr;
    m_valid_d     = m_valid_q && !m_axis_tready;
    m_data_d      = m_data_q;
    case (state_q)
      ST_INIT: begin
        if (sw_wr.last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (finish) begin
          m_valid_d = 1'b1;
          m_data_d  = '0;
          state_d   = ST_IDLE;
          case (kind_q)
            mcms_pkg::KIND_SET_WALL: begin
              if (ok_q) begin
                wall_we    = 1'b1;
                wall_waddr = addr_q;
                wall_wdata = wall_update(wall_rd_q, dir_q, pres_q);
                if (nb_ok_q) begin
                  wall_re    = 1'b1;
                  wall_raddr = nb_addr_q;
                  state_d    = ST_NB;
                end
              end
            end
            mcms_pkg::KIND_QUERY_WALL: m_data_d[0] = ok_q ? wall_rd_q[dir_q] : 1'b1;
            mcms_pkg::KIND_SET_DIST: begin
              if (ok_q) begin
                dv_we    = 1'b1;
                dv_waddr = addr_q;
                dv_wdata = {dv_rd_q[8], dval_q};
              end
            end
            mcms_pkg::KIND_GET_DIST:
              m_data_d[8:1] = ok_q ? dv_rd_q[7:0] : mcms_pkg::DIST_INVALID;
            mcms_pkg::KIND_MARK_VIS: begin
              if (ok_q) begin
                dv_we    = 1'b1;
                dv_waddr = addr_q;
                dv_wdata = {1'b1, dv_rd_q[7:0]};
              end
            end
            mcms_pkg::KIND_QUERY_VIS: m_data_d[9] = ok_q && dv_rd_q[8];
            mcms_pkg::KIND_CLEAR: begin
              sw_ctrl.start = 1'b1;
              state_d       = ST_CLR;
            end
            default: m_data_d = '0;
          endcase
        end
      end
      ST_NB: begin
        wall_we    = 1'b1;
        wall_waddr = nb_addr_q;
        wall_wdata = wall_update(wall_rd_q, dir_q + 2'd2, pres_q);
        state_d    = ST_IDLE;
      end
      ST_CLR: begin
        if (sw_wr.last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wall_we) wall_mem[wall_waddr] <= wall_wdata;
    if (wall_re) wall_rd_q <= wall_mem[wall_raddr];
    if (dv_we) dv_mem[dv_waddr] <= dv_wdata;
    if (dv_re) dv_rd_q <= dv_mem[dv_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= s_axis_tuser;
      dir_q     <= in_dir;
      pres_q    <= s_axis_tdata[18];
      dval_q    <= in_dval;
      ok_q      <= in_ok;
      nb_ok_q   <= nb_ok;
      addr_q    <= in_addr;
      nb_addr_q <= nb_addr;
    end
    m_data_q <= m_data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      m_valid_q <= 1'b0;
      goal_x_q  <= 4'd7;
      goal_y_q  <= 4'd7;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          mcms_pkg::CFG_GOAL_X: goal_x_q <= cfg_data_i;
          mcms_pkg::CFG_GOAL_Y: goal_y_q <= cfg_data_i;
          default: goal_x_q <= goal_x_q;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/maze_cell_map_store_checker.sv
// Scoreboard for the maze cell map store: watches the s_axis, m_axis and cfg channels,
// keeps its own copy of the wall, distance and visited maps and compares every answer.
// Depends on mcms_pkg.
module maze_cell_map_store_checker
  import mcms_pkg::*;
#(
  parameter int unsigned GRID_SIDE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [31:0] s_data_i,   // pos_x, pos_y, direction, wall_present, distance_value
  input  logic [2:0]  s_user_i,   // kind
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [15:0] m_data_i,   // wall_seen, distance_out, visited_out
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = GRID_SIDE * GRID_SIDE;

  typedef struct packed {
    logic       visited;
    logic [7:0] distance;
    logic       wall;
  } map_answer_t;

  logic [3:0]  wall_map  [CELLS];
  logic [7:0]  dist_map  [CELLS];
  logic        visit_map [CELLS];
  logic [3:0]  goal_col;
  logic [3:0]  goal_row;
  map_answer_t answer_q  [$];
  int unsigned fail_count = 0;

  assign fail_count_o = fail_count;

  function automatic int abs_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int cell_index(int x, int y);
    return x * GRID_SIDE + y;
  endfunction

  function automatic logic on_grid(int x, int y);
    return x >= 0 && x < GRID_SIDE && y >= 0 && y < GRID_SIDE;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("checker: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic load_reset_map();
    int lo;
    int hi;
    int dx;
    int dy;
    lo = GRID_SIDE / 2 - 1;
    hi = GRID_SIDE / 2;
    goal_col = 4'd7;
    goal_row = 4'd7;
    for (int x = 0; x < GRID_SIDE; x++) begin
      for (int y = 0; y < GRID_SIDE; y++) begin
        dx = (abs_gap(x, lo) < abs_gap(x, hi)) ? abs_gap(x, lo) : abs_gap(x, hi);
        dy = (abs_gap(y, lo) < abs_gap(y, hi)) ? abs_gap(y, lo) : abs_gap(y, hi);
        wall_map[cell_index(x, y)] = {x == 0, y == 0, x == GRID_SIDE - 1, y == GRID_SIDE - 1};
        dist_map[cell_index(x, y)] = 8'(dx + dy);
        visit_map[cell_index(x, y)] = 1'b0;
      end
    end
  endtask

  task automatic write_wall(int x, int y, logic [1:0] d, logic present);
    logic [3:0] mask;
    mask = 4'b0001 << d;
    if (present) begin
      wall_map[cell_index(x, y)] = wall_map[cell_index(x, y)] | mask;
    end else begin
      wall_map[cell_index(x, y)] = wall_map[cell_index(x, y)] & ~mask;
    end
  endtask

  task automatic apply_map_op(input logic [2:0] kind, input int x, input int y,
                              input logic [1:0] d, input logic present,
                              input logic [7:0] dval, output map_answer_t ans);
    logic ok;
    int   nx;
    int   ny;
    ans = '0;
    ok  = on_grid(x, y);
    nx  = x;
    ny  = y;
    case (kind)
      KIND_SET_WALL: begin
        if (ok) begin
          write_wall(x, y, d, present);
          case (d)
            DIR_N:   ny = y + 1;
            DIR_E:   nx = x + 1;
            DIR_S:   ny = y - 1;
            default: nx = x - 1;
          endcase
          if (on_grid(nx, ny)) write_wall(nx, ny, d + 2'd2, present);
        end
      end
      KIND_QUERY_WALL: begin
        ans.wall = ok ? |(wall_map[cell_index(x, y)] & (4'b0001 << d)) : 1'b1;
      end
      KIND_SET_DIST: begin
        if (ok) dist_map[cell_index(x, y)] = dval;
      end
      KIND_GET_DIST: begin
        ans.distance = ok ? dist_map[cell_index(x, y)] : DIST_INVALID;
      end
      KIND_MARK_VIS: begin
        if (ok) visit_map[cell_index(x, y)] = 1'b1;
      end
      KIND_QUERY_VIS: begin
        ans.visited = ok ? visit_map[cell_index(x, y)] : 1'b0;
      end
      KIND_CLEAR: begin
        for (int cx = 0; cx < GRID_SIDE; cx++) begin
          for (int cy = 0; cy < GRID_SIDE; cy++) begin
            dist_map[cell_index(cx, cy)] =
              8'(abs_gap(cx, int'(goal_col)) + abs_gap(cy, int'(goal_row)));
            visit_map[cell_index(cx, cy)] = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    map_answer_t want;
    map_answer_t got;
    if (!rst_ni) begin
      load_reset_map();
      answer_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_GOAL_X) begin
          goal_col = cfg_data_i;
        end else begin
          goal_row = cfg_data_i;
        end
      end
      if (m_valid_i && m_ready_i) begin
        got = m_data_i[9:0];
        if (answer_q.size() == 0) begin
          report_mismatch("answer with nothing pending, tdata", m_data_i, 0);
        end else begin
          want = answer_q.pop_front();
          if (got.wall != want.wall) report_mismatch("wall_seen", got.wall, want.wall);
          if (got.distance != want.distance) begin
            report_mismatch("distance_out", got.distance, want.distance);
          end
          if (got.visited != want.visited) begin
            report_mismatch("visited_out", got.visited, want.visited);
          end
        end
      end
      if (s_valid_i && s_ready_i) begin
        apply_map_op(s_user_i, int'(s_data_i[7:0]), int'(s_data_i[15:8]), s_data_i[17:16],
                     s_data_i[18], s_data_i[26:19], want);
        answer_q.push_back(want);
      end
      pending_o <= answer_q.size();
    end
  end

endmodule

FILE: tb/maze_cell_map_store_top_tb.sv
// Testbench top for maze_cell_map_store_top: reset, directed and random map operations,
// goal register phases, random stalls on both streams, watchdog and verdict.
// Depends on mcms_pkg, maze_cell_map_store_top and maze_cell_map_store_checker.
module maze_cell_map_store_top_tb;
  import mcms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GRID_SIDE   = 16;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_OPS   = 300;
  localparam logic [2:0]  KIND_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [1:0] dir;
    logic       wp;
    logic [7:0] dv;
  } map_op_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [3:0]  cfg_data_i;

  int unsigned fail_count;
  int unsigned answers_pending;
  int unsigned quiet_cycles = 0;
  bit          send_burst = 1'b0;

  maze_cell_map_store_top #(
    .GRID_SIDE(GRID_SIDE)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  maze_cell_map_store_checker #(
    .GRID_SIDE(GRID_SIDE)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (answers_pending)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic map_op_t map_op(logic [2:0] kind, logic [7:0] x, logic [7:0] y,
                                     logic [1:0] dir, logic wp, logic [7:0] dv);
    map_op_t op;
    op.kind = kind;
    op.x    = x;
    op.y    = y;
    op.dir  = dir;
    op.wp   = wp;
    op.dv   = dv;
    return op;
  endfunction

  function automatic logic [7:0] pick_coord();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return 8'($urandom_range(0, GRID_SIDE - 1));
    if (r < 17) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'(GRID_SIDE - 1);
      2:       return 8'(GRID_SIDE);
      default: return 8'd255;
    endcase
  endfunction

  function automatic map_op_t random_op(map_op_t prev);
    map_op_t op;
    int      r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      op.kind = KIND_CLEAR;
    end else if (r < 5) begin
      op.kind = KIND_UNUSED;
    end else begin
      op.kind = 3'($urandom_range(0, 5));
    end
    if ($urandom_range(0, 9) < 4) begin
      op.x = prev.x;
      op.y = prev.y;
    end else begin
      op.x = pick_coord();
      op.y = pick_coord();
    end
    op.dir = 2'($urandom_range(0, 3));
    op.wp  = 1'($urandom_range(0, 1));
    op.dv  = 8'($urandom_range(0, 255));
    return op;
  endfunction

  task automatic send_op(map_op_t op);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, op.dv, op.wp, op.dir, op.y, op.x};
    s_axis_tuser  <= op.kind;
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (answers_pending != 0) @(posedge clk_i);
  endtask

  task automatic set_goal(logic [3:0] gx, logic [3:0] gy);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_GOAL_X;
    cfg_data_i  <= gx;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_GOAL_Y;
    cfg_data_i  <= gy;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_directed();
    send_op(map_op(KIND_QUERY_WALL, 8'd0, 8'd0, DIR_S, 1'b0, 8'd0));
    send_op(map_op(KIND_QUERY_WALL, 8'd0, 8'd0, DIR_W, 1'b0, 8'd0));
    send_op(map_op(KIND_QUERY_WALL, 8'd15, 8'd15, DIR_N, 1'b0, 8'd0));
    send_op(map_op(KIND_QUERY_WALL, 8'd15, 8'd15, DIR_E, 1'b0, 8'd0));
    send_op(map_op(KIND_SET_WALL, 8'd0, 8'd0, DIR_S, 1'b0, 8'd0));
    send_op(map_op(KIND_QUERY_WALL, 8'd0, 8'd0, DIR_S, 1'b0, 8'd0));
    send_op(map_op(KIND_SET_WALL, 8'd3, 8'd4, DIR_N, 1'b1, 8'd0));
    send_op(map_op(KIND_QUERY_WALL, 8'd3, 8'd5, DIR_S, 1'b0, 8'd0));
    send_op(map_op(KIND_SET_WALL, 8'd3, 8'd5, DIR_S, 1'b0, 8'd0));
    send_op(map_op(KIND_QUERY_WALL, 8'd3, 8'd4, DIR_N, 1'b0, 8'd0));
    send_op(map_op(KIND_QUERY_WALL, 8'd16, 8'd0, DIR_N, 1'b0, 8'd0));
    send_op(map_op(KIND_SET_WALL, 8'd255, 8'd3, DIR_E, 1'b1, 8'd0));
    send_op(map_op(KIND_GET_DIST, 8'd0, 8'd0, DIR_N, 1'b0, 8'd0));
    send_op(map_op(KIND_GET_DIST, 8'd7, 8'd8, DIR_N, 1'b0, 8'd0));
    send_op(map_op(KIND_SET_DIST, 8'd15, 8'd0, DIR_N, 1'b0, 8'd255));
    send_op(map_op(KIND_GET_DIST, 8'd15, 8'd0, DIR_N, 1'b0, 8'd0));
    send_op(map_op(KIND_SET_DIST, 8'd16, 8'd16, DIR_N, 1'b0, 8'd200));
    send_op(map_op(KIND_GET_DIST, 8'd0, 8'd255, DIR_N, 1'b0, 8'd0));
    send_op(map_op(KIND_MARK_VIS, 8'd5, 8'd5, DIR_N, 1'b0, 8'd0));
    send_op(map_op(KIND_QUERY_VIS, 8'd5, 8'd5, DIR_N, 1'b0, 8'd0));
    send_op(map_op(KIND_MARK_VIS, 8'd200, 8'd1, DIR_N, 1'b0, 8'd0));
    send_op(map_op(KIND_QUERY_VIS, 8'd255, 8'd255, DIR_N, 1'b0, 8'd0));
    send_op(map_op(KIND_UNUSED, 8'd255, 8'd255, DIR_W, 1'b1, 8'd255));
    send_op(map_op(KIND_CLEAR, 8'd255, 8'd255, DIR_W, 1'b1, 8'd255));
    send_op(map_op(KIND_GET_DIST, 8'd0, 8'd0, DIR_N, 1'b0, 8'd0));
    send_op(map_op(KIND_QUERY_VIS, 8'd5, 8'd5, DIR_N, 1'b0, 8'd0));
  endtask

  initial begin : stimulus
    map_op_t    op;
    logic [3:0] gx;
    logic [3:0] gy;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_GOAL_X;
    cfg_data_i    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    op = map_op(KIND_QUERY_WALL, 8'd0, 8'd0, DIR_N, 1'b0, 8'd0);
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        case (phase)
          1: begin gx = 4'd0;  gy = 4'd0;  end
          2: begin gx = 4'd15; gy = 4'd15; end
          3: begin gx = 4'd15; gy = 4'd0;  end
          4: begin gx = 4'd0;  gy = 4'd15; end
          default: begin
            gx = 4'($urandom_range(0, 15));
            gy = 4'($urandom_range(0, 15));
          end
        endcase
        wait_drained();
        repeat (4) @(posedge clk_i);
        set_goal(gx, gy);
        send_op(map_op(KIND_CLEAR, 8'd0, 8'd0, DIR_N, 1'b0, 8'd0));
        send_op(map_op(KIND_GET_DIST, 8'd0, 8'd0, DIR_N, 1'b0, 8'd0));
        send_op(map_op(KIND_GET_DIST, 8'd15, 8'd15, DIR_N, 1'b0, 8'd0));
      end
      for (int n = 0; n < PHASE_OPS; n++) begin
        op = random_op(op);
        send_op(op);
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
    end
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("maze_cell_map_store_top_tb: clean");
    end else begin
      $display("maze_cell_map_store_top_tb: errors");
    end
    $finish;
  end

  initial begin : sink
    int stall;
    bit burst;
    burst         = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      stall = burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if ($urandom_range(0, 39) == 0) burst = !burst;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("maze_cell_map_store_top_tb: errors");
      $finish;
    end
  end

endmodule
